// ----- rtl/dba_pkg.sv -----
`timescale 1ns / 1ps

package dba_pkg;

    localparam int DEF_TABLE_SIZE = 256;
    localparam int DEF_WORD_BITS  = 64;

    localparam int       LIMIT_W     = 9;
    localparam bit [8:0] LIMIT_RESET = 9'd256;

    // operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_INSTALL = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_TAKEN   = 2'd2;

    typedef struct packed {
        logic load;        // capture the accepted item, clear the result
        logic scan;        // examine one bitmap word
        logic commit;      // finish an allocation
        logic install;     // perform an install
        logic lookup_rd;   // issue the handle store read
        logic lookup_cap;  // capture the handle store data
        logic out_load;    // move the result to the output register
    } dba_cmd_t;

    typedef struct packed {
        logic scan_done;   // free bit found or table exhausted
        logic out_free;    // output register can take a result
    } dba_stat_t;

endpackage

// ----- rtl/dba_ram.sv -----
`timescale 1ns / 1ps

module dba_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/dba_ctrl.sv -----
`timescale 1ns / 1ps

module dba_ctrl
    import dba_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  dba_stat_t  stat,
    output dba_cmd_t   cmd
);

    typedef enum logic [6:0] {
        S_IDLE       = 7'b0000001,
        S_SCAN       = 7'b0000010,
        S_COMMIT     = 7'b0000100,
        S_INSTALL    = 7'b0001000,
        S_LOOKUP_RD  = 7'b0010000,
        S_LOOKUP_CAP = 7'b0100000,
        S_DONE       = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_operation)
                        OP_ALLOC:   state_next = S_SCAN;
                        OP_INSTALL: state_next = S_INSTALL;
                        OP_LOOKUP:  state_next = S_LOOKUP_RD;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = S_DONE;
            end
            S_INSTALL: begin
                cmd.install = 1'b1;
                state_next  = S_DONE;
            end
            S_LOOKUP_RD: begin
                cmd.lookup_rd = 1'b1;
                state_next    = S_LOOKUP_CAP;
            end
            S_LOOKUP_CAP: begin
                cmd.lookup_cap = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/dba_datapath.sv -----
`timescale 1ns / 1ps

module dba_datapath
    import dba_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dba_cmd_t           cmd,
    output dba_stat_t          stat,
    input  logic [7:0]         s_start_index,
    input  logic               s_want_close_on_exec,
    input  logic [7:0]         s_slot_index,
    input  logic [31:0]        s_handle_value,
    input  logic               s_handle_is_path,
    input  logic               cfg_valid,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [1:0]         m_status,
    output logic [7:0]         m_descriptor,
    output logic [31:0]        m_found_handle,
    output logic               m_handle_found
);

    localparam int IDX_W     = $clog2(TABLE_SIZE);
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int NUM_WORDS = TABLE_SIZE / WORD_BITS;
    localparam int WC_W      = $clog2(NUM_WORDS + 1);
    localparam int WI_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int HINT_W    = IDX_W + 1;
    localparam int CMP_W     = (HINT_W > LIMIT_W) ? HINT_W : LIMIT_W;

    function automatic logic [OFF_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] word);
        logic [OFF_W-1:0] pos;
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!word[b]) begin
                pos = OFF_W'(b);
            end
        end
        return pos;
    endfunction

    // captured item
    logic [7:0]  start_reg;
    logic        cloexec_reg;
    logic [7:0]  slot_reg;
    logic [31:0] handle_reg;
    logic        path_reg;

    // table state
    logic [HINT_W-1:0]     hint_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [TABLE_SIZE-1:0] open_map_reg;
    logic [TABLE_SIZE-1:0] exec_map_reg;
    logic [TABLE_SIZE-1:0] inst_map_reg;
    logic [NUM_WORDS-1:0]  full_map_reg;

    // search state
    logic [WC_W-1:0]  scan_word_reg;
    logic [OFF_W-1:0] off_reg;
    logic             first_reg;
    logic [IDX_W-1:0] fd_reg;
    logic             found_reg;

    // pending result and output register
    logic [1:0]  res_status_reg;
    logic [7:0]  res_desc_reg;
    logic [31:0] res_handle_reg;
    logic        res_flag_reg;
    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [7:0]  m_desc_reg;
    logic [31:0] m_handle_reg;
    logic        m_flag_reg;

    logic [CMP_W-1:0]     start_ext, hint_ext, from_idx;
    logic [WI_W-1:0]      w_idx;
    logic                 scan_end;
    logic [IDX_W-1:0]     base;
    logic [WORD_BITS-1:0] low_mask, scan_word_eff;
    logic                 word_has_free;
    logic [OFF_W-1:0]     free_pos;
    logic [IDX_W-1:0]     fd_base;
    logic [WI_W-1:0]      fd_widx;
    logic [WORD_BITS-1:0] fd_word_set;
    logic                 fd_ok;
    logic                 slot_ok;
    logic [IDX_W-1:0]     slot_addr;
    logic                 slot_used;
    logic                 ram_we;
    logic [32:0]          ram_rdata;

    always_comb begin
        start_ext = CMP_W'(s_start_index);
        hint_ext  = CMP_W'(hint_reg);
        from_idx  = (start_ext < hint_ext) ? hint_ext : start_ext;

        w_idx         = scan_word_reg[WI_W-1:0];
        scan_end      = (scan_word_reg == WC_W'(NUM_WORDS));
        base          = IDX_W'(w_idx) << OFF_W;
        // bits below the starting offset count as taken in the first word
        low_mask      = first_reg ? ((WORD_BITS'(1) << off_reg) - WORD_BITS'(1)) : '0;
        scan_word_eff = open_map_reg[base +: WORD_BITS] | low_mask;
        word_has_free = !full_map_reg[w_idx] && !(&scan_word_eff);
        free_pos      = lowest_zero(scan_word_eff);

        fd_base     = (fd_reg >> OFF_W) << OFF_W;
        fd_widx     = WI_W'(fd_reg >> OFF_W);
        fd_word_set = open_map_reg[fd_base +: WORD_BITS]
                    | (WORD_BITS'(1) << fd_reg[OFF_W-1:0]);
        fd_ok       = found_reg && (CMP_W'(fd_reg) < CMP_W'(limit_reg));

        slot_ok   = CMP_W'(slot_reg) < CMP_W'(TABLE_SIZE);
        slot_addr = IDX_W'(slot_reg);
        slot_used = inst_map_reg[slot_addr];
        ram_we    = cmd.install && slot_ok && !slot_used && (handle_reg != 32'd0);
    end

    assign stat.scan_done = scan_end || word_has_free;
    assign stat.out_free  = !m_valid_reg || m_ready;

    dba_ram #(
        .WIDTH (33),
        .DEPTH (TABLE_SIZE)
    ) u_handle_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (slot_addr),
        .wr_data ({path_reg, handle_reg}),
        .rd_en   (cmd.lookup_rd),
        .rd_addr (slot_addr),
        .rd_data (ram_rdata)
    );

    // table state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hint_reg     <= '0;
            limit_reg    <= LIMIT_RESET;
            open_map_reg <= '0;
            exec_map_reg <= '0;
            inst_map_reg <= '0;
            full_map_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_data;
            end
            if (cmd.commit && fd_ok) begin
                open_map_reg[fd_reg] <= 1'b1;
                exec_map_reg[fd_reg] <= cloexec_reg;
                if (&fd_word_set) begin
                    full_map_reg[fd_widx] <= 1'b1;
                end
                if (CMP_W'(start_reg) <= CMP_W'(hint_reg)) begin
                    hint_reg <= {1'b0, fd_reg} + HINT_W'(1);
                end
            end
            if (ram_we) begin
                inst_map_reg[slot_addr] <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item capture, search and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            start_reg      <= s_start_index;
            cloexec_reg    <= s_want_close_on_exec;
            slot_reg       <= s_slot_index;
            handle_reg     <= s_handle_value;
            path_reg       <= s_handle_is_path;
            res_status_reg <= ST_OK;
            res_desc_reg   <= '0;
            res_handle_reg <= '0;
            res_flag_reg   <= 1'b0;
            first_reg      <= 1'b1;
            off_reg        <= from_idx[OFF_W-1:0];
            if (from_idx >= CMP_W'(TABLE_SIZE)) begin
                scan_word_reg <= WC_W'(NUM_WORDS);
            end else begin
                scan_word_reg <= WC_W'(from_idx >> OFF_W);
            end
        end
        if (cmd.scan) begin
            if (scan_end) begin
                found_reg <= 1'b0;
            end else if (word_has_free) begin
                found_reg <= 1'b1;
                fd_reg    <= base | IDX_W'(free_pos);
            end else begin
                // advance to the next word
                scan_word_reg <= scan_word_reg + WC_W'(1);
                first_reg     <= 1'b0;
            end
        end
        if (cmd.commit) begin
            if (fd_ok) begin
                res_desc_reg <= 8'(fd_reg);
            end else begin
                res_status_reg <= ST_NO_FREE;
            end
        end
        if (cmd.install) begin
            if (!slot_ok) begin
                res_status_reg <= ST_NO_FREE;
            end else if (slot_used) begin
                res_status_reg <= ST_TAKEN;
            end
        end
        if (cmd.lookup_cap) begin
            if (slot_ok && slot_used && !ram_rdata[32]) begin
                res_handle_reg <= ram_rdata[31:0];
                res_flag_reg   <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_desc_reg   <= res_desc_reg;
            m_handle_reg <= res_handle_reg;
            m_flag_reg   <= res_flag_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_descriptor   = m_desc_reg;
    assign m_found_handle = m_handle_reg;
    assign m_handle_found = m_flag_reg;

endmodule

// ----- rtl/descriptor_bitmap_allocator_core.sv -----
`timescale 1ns / 1ps
// Descriptor table with a lowest-free allocator, handle install and lookup.
// Input channel s_*: one item per operation (allocate, install, lookup).
// Result channel m_*: exactly one item per accepted input item, in order.
// Configuration channel cfg_*: writes the descriptor limit; cfg_ready is
// always high. Write it only while no operation is in progress.
// Steps from input accept to m_valid: allocate searches the bitmap one word
// per cycle through the scan loop (the search visits 1 to words + 1 words),
// then commits; install writes the handle store; lookup reads the handle
// store (the read is registered), then captures its data. Unused operation codes go straight to the result.
// One item is in work at a time; s_ready rises again the cycle after its
// result moves into the output register.
// A result waiting in the output register does not block the next accept;
// only a second finished result waits for m_ready.
// Reset (aresetn low, synchronous) clears the open, close-on-exec, installed
// and word-full bitmaps, the next-free hint and the output valid, and sets
// the limit to 256. The handle store is not cleared; the installed bitmap
// guards every read of it.
module descriptor_bitmap_allocator_core
    import dba_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE,
    parameter int WORD_BITS  = DEF_WORD_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [7:0]         s_start_index,
    input  logic               s_want_close_on_exec,
    input  logic [7:0]         s_slot_index,
    input  logic [31:0]        s_handle_value,
    input  logic               s_handle_is_path,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [7:0]         m_descriptor,
    output logic [31:0]        m_found_handle,
    output logic               m_handle_found,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data
);

    dba_cmd_t  cmd;
    dba_stat_t stat;

    assign cfg_ready = 1'b1;

    dba_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .stat        (stat),
        .cmd         (cmd)
    );

    dba_datapath #(
        .TABLE_SIZE (TABLE_SIZE),
        .WORD_BITS  (WORD_BITS)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .stat                 (stat),
        .s_start_index        (s_start_index),
        .s_want_close_on_exec (s_want_close_on_exec),
        .s_slot_index         (s_slot_index),
        .s_handle_value       (s_handle_value),
        .s_handle_is_path     (s_handle_is_path),
        .cfg_valid            (cfg_valid && cfg_ready),
        .cfg_data             (cfg_data),
        .m_ready              (m_ready),
        .m_valid              (m_valid),
        .m_status             (m_status),
        .m_descriptor         (m_descriptor),
        .m_found_handle       (m_found_handle),
        .m_handle_found       (m_handle_found)
    );

    // one item in work at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in work");

    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid)
        else $error("loaded result not presented");

    a_commit_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> $past(cmd.scan && stat.scan_done))
        else $error("allocation committed without a finished search");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_NO_FREE || m_status == ST_TAKEN))
        else $error("undefined status code on result");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import dba_pkg::*;

    localparam int TBL_SIZE       = DEF_TABLE_SIZE;
    localparam int WBITS          = DEF_WORD_BITS;
    localparam int NWORDS         = TBL_SIZE / WBITS;
    localparam int ITEMS_PER_SET  = 305;
    localparam int STEADY_ITEMS   = 150;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_PRINTS     = 20;

    // no name in the package for the spare operation code
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  descriptor;
        logic [31:0] handle;
        logic        found;
    } table_result_t;

    class descriptor_table_mirror;
        bit          open_map[TBL_SIZE];
        bit          full_word[NWORDS];
        bit          cloexec_map[TBL_SIZE];
        bit          installed[TBL_SIZE];
        bit          path_only[TBL_SIZE];
        bit [31:0]   handles[TBL_SIZE];
        bit [8:0]    hint;
        bit [8:0]    limit;
        table_result_t awaited[$];
        int          mismatches;
        int          checked;
        int          op_count[4];
        int          granted;
        int          refused;

        function new();
            limit = LIMIT_RESET;
            hint = '0;
        endfunction

        function int lowest_free(int from);
            int w;
            w = from / WBITS;
            while (w < NWORDS && full_word[w])
                w++;
            if (w * WBITS > from)
                from = w * WBITS;
            for (int i = from; i < TBL_SIZE; i++)
                if (!open_map[i])
                    return i;
            return TBL_SIZE;
        endfunction

        function void mark_open(int fd);
            int w;
            bit full;
            w = fd / WBITS;
            full = 1'b1;
            open_map[fd] = 1'b1;
            for (int b = 0; b < WBITS; b++)
                if (!open_map[w * WBITS + b])
                    full = 1'b0;
            if (full)
                full_word[w] = 1'b1;
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] start, logic cloexec,
                                   logic [7:0] slot, logic [31:0] handle, logic is_path);
            int fd;
            table_result_t r;
            r = '0;
            op_count[op]++;
            case (op)
                OP_ALLOC: begin
                    fd = int'(start);
                    if (fd < int'(hint))
                        fd = int'(hint);
                    if (fd < TBL_SIZE)
                        fd = lowest_free(fd);
                    if (fd >= int'(limit) || fd >= TBL_SIZE) begin
                        r.status = ST_NO_FREE;
                        refused++;
                    end else begin
                        if (int'(start) <= int'(hint))
                            hint = 9'(fd + 1);
                        mark_open(fd);
                        cloexec_map[fd] = cloexec;
                        r.descriptor = 8'(fd);
                        granted++;
                    end
                end
                OP_INSTALL: begin
                    if (installed[slot]) begin
                        r.status = ST_TAKEN;
                    end else if (handle != '0) begin
                        installed[slot] = 1'b1;
                        handles[slot] = handle;
                        path_only[slot] = is_path;
                    end
                end
                OP_LOOKUP: begin
                    if (installed[slot] && !path_only[slot]) begin
                        r.handle = handles[slot];
                        r.found = 1'b1;
                    end
                end
                default: ;
            endcase
            awaited.push_back(r);
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("mismatch on %s: got %h, expected %h (result %0d)",
                         what, got, want, checked);
        endtask

        task check_result(table_result_t got);
            table_result_t want;
            if (awaited.size() == 0) begin
                flag_mismatch("result with nothing pending", got.descriptor, '0);
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (got.status !== want.status)
                flag_mismatch("status", got.status, want.status);
            if (got.descriptor !== want.descriptor)
                flag_mismatch("descriptor", got.descriptor, want.descriptor);
            if (got.handle !== want.handle)
                flag_mismatch("found_handle", got.handle, want.handle);
            if (got.found !== want.found)
                flag_mismatch("handle_found", got.found, want.found);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation = '0;
    logic [7:0]  s_start_index = '0;
    logic        s_want_close_on_exec = 1'b0;
    logic [7:0]  s_slot_index = '0;
    logic [31:0] s_handle_value = '0;
    logic        s_handle_is_path = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_descriptor;
    logic [31:0] m_found_handle;
    logic        m_handle_found;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [LIMIT_W-1:0] cfg_data = '0;

    logic        steady = 1'b0;
    bit          stored[TBL_SIZE];
    logic [7:0]  stored_slots[$];
    int          quiet_cycles = 0;

    descriptor_table_mirror mirror = new();

    descriptor_bitmap_allocator_core uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_start_index       (s_start_index),
        .s_want_close_on_exec(s_want_close_on_exec),
        .s_slot_index        (s_slot_index),
        .s_handle_value      (s_handle_value),
        .s_handle_is_path    (s_handle_is_path),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_descriptor        (m_descriptor),
        .m_found_handle      (m_found_handle),
        .m_handle_found      (m_handle_found),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 26);
    end

    // sample pre-edge values: every handshake at this edge, then the watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                mirror.limit = cfg_data;
            if (s_valid && s_ready)
                mirror.note_request(s_operation, s_start_index, s_want_close_on_exec,
                                    s_slot_index, s_handle_value, s_handle_is_path);
            if (m_valid && m_ready)
                mirror.check_result(table_result_t'({m_status, m_descriptor,
                                                     m_found_handle, m_handle_found}));
            if ((cfg_valid && cfg_ready) || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d results pending",
                         quiet_cycles, mirror.awaited.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] start,
                             input logic cloexec, input logic [7:0] slot,
                             input logic [31:0] handle, input logic is_path);
        int gap;
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < 26)
                gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        // random lookups target slots whose handle was written
        if (op == OP_INSTALL && handle != '0 && !stored[slot]) begin
            stored[slot] = 1'b1;
            stored_slots.push_back(slot);
        end
        s_valid              <= 1'b1;
        s_operation          <= op;
        s_start_index        <= start;
        s_want_close_on_exec <= cloexec;
        s_slot_index         <= slot;
        s_handle_value       <= handle;
        s_handle_is_path     <= is_path;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_item();
        int pick;
        int sel;
        logic [1:0]  op;
        logic [7:0]  start;
        logic [7:0]  slot;
        logic [31:0] handle;
        pick = $urandom_range(99);
        if (pick < 40)
            op = OP_ALLOC;
        else if (pick < 70)
            op = OP_INSTALL;
        else if (pick < 95)
            op = OP_LOOKUP;
        else
            op = OP_UNUSED;
        sel = $urandom_range(9);
        if (sel < 4)
            start = '0;
        else if (sel < 7)
            start = 8'($urandom_range(63));
        else
            start = 8'($urandom_range(255));
        slot = 8'($urandom_range(255));
        if (op == OP_LOOKUP) begin
            if (stored_slots.size() == 0)
                op = OP_INSTALL;
            else
                slot = stored_slots[$urandom_range(stored_slots.size() - 1)];
        end
        sel = $urandom_range(19);
        if (sel == 0)
            handle = '0;
        else if (sel == 1)
            handle = '1;
        else
            handle = $urandom;
        send_item(op, start, 1'($urandom_range(1)), slot, handle,
                  1'($urandom_range(9) < 3));
    endtask

    // hold the sender until every pending result is back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (mirror.awaited.size() != 0);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    logic [LIMIT_W-1:0] limit_sweep[6] = '{9'd0, 9'd37, 9'd100, 9'd255, 9'd200, 9'd256};

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lowest free, hint skipped by a high start, end of table
        send_item(OP_ALLOC, 8'd0, 1'b0, 8'd0, 32'h0, 1'b0);
        send_item(OP_ALLOC, 8'd0, 1'b1, 8'd0, 32'h0, 1'b0);
        send_item(OP_ALLOC, 8'd255, 1'b1, 8'd0, 32'h0, 1'b0);
        send_item(OP_ALLOC, 8'd255, 1'b0, 8'd0, 32'h0, 1'b0);
        send_item(OP_ALLOC, 8'd5, 1'b1, 8'd0, 32'h0, 1'b0);
        send_item(OP_ALLOC, 8'd0, 1'b0, 8'd0, 32'h0, 1'b0);
        send_item(OP_ALLOC, 8'd64, 1'b1, 8'd0, 32'h0, 1'b0);
        send_item(OP_ALLOC, 8'd3, 1'b0, 8'd0, 32'h0, 1'b0);
        // install: plain, zero handle, path-only, occupied slot
        send_item(OP_INSTALL, 8'd0, 1'b0, 8'd0, 32'hFFFF_FFFF, 1'b0);
        send_item(OP_INSTALL, 8'd0, 1'b0, 8'd255, 32'h0, 1'b0);
        send_item(OP_INSTALL, 8'd0, 1'b0, 8'd255, 32'hA5A5_5A5A, 1'b1);
        send_item(OP_INSTALL, 8'd0, 1'b0, 8'd0, 32'h0000_0001, 1'b0);
        send_item(OP_INSTALL, 8'hFF, 1'b1, 8'd128, 32'h5A5A_A5A5, 1'b0);
        send_item(OP_INSTALL, 8'd0, 1'b0, 8'd255, 32'h1234_5678, 1'b0);
        send_item(OP_LOOKUP, 8'd0, 1'b0, 8'd0, 32'h0, 1'b0);
        send_item(OP_LOOKUP, 8'd0, 1'b0, 8'd255, 32'h0, 1'b0);
        send_item(OP_LOOKUP, 8'hFF, 1'b1, 8'd128, 32'hFFFF_FFFF, 1'b1);
        // lookup of an empty slot
        send_item(OP_LOOKUP, 8'd0, 1'b0, 8'd77, 32'h0, 1'b0);
        send_item(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_UNUSED, 8'd0, 1'b0, 8'd0, 32'h0, 1'b0);

        foreach (limit_sweep[p]) begin
            wait_for_results();
            write_limit(limit_sweep[p]);
            for (int i = 0; i < ITEMS_PER_SET; i++) begin
                steady <= (p == 3) && (i < STEADY_ITEMS);
                if (i == ITEMS_PER_SET / 2)
                    wait_for_results();
                send_random_item();
            end
        end

        wait_for_results();
        steady <= 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mirror.awaited.size() != 0)
            mirror.flag_mismatch("results never returned", mirror.awaited.size(), '0);

        $display("checked %0d results: %0d allocate, %0d install, %0d lookup, %0d spare-op",
                 mirror.checked, mirror.op_count[OP_ALLOC], mirror.op_count[OP_INSTALL],
                 mirror.op_count[OP_LOOKUP], mirror.op_count[OP_UNUSED]);
        $display("allocations granted %0d, refused %0d over 6 limit settings; %0d slots hold handles",
                 mirror.granted, mirror.refused, stored_slots.size());
        if (mirror.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/dba_pkg.sv
rtl/dba_ram.sv
rtl/dba_ctrl.sv
rtl/dba_datapath.sv
rtl/descriptor_bitmap_allocator_core.sv
dv/tb_top.sv
